// File: rtl/sqb_pkg.sv
package sqb_pkg;

	localparam int TEXTURE_SLOTS = 32;
	localparam int MAX_QUADS     = 8192;

	// slot counter holds 0..TEXTURE_SLOTS, slot address 0..TEXTURE_SLOTS-1
	localparam int CNT_W   = $clog2(TEXTURE_SLOTS + 1);
	localparam int SLOT_AW = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;
	localparam int QUAD_W  = $clog2(MAX_QUADS + 1);

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		KIND_VERTEX    = 3'd0,
		KIND_REJ_BATCH = 3'd1,
		KIND_REJ_TABLE = 3'd2,
		KIND_BIND      = 3'd3,
		KIND_DRAW      = 3'd4
	} kind_t;

	// one queued job: a sprite to expand, or a single record
	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] w;
		logic signed [31:0] h;
		logic [31:0]        color;
		logic [5:0]         slot;
		logic [31:0]        texture;
		logic [15:0]        count;
	} job_t;

	function automatic logic [5:0] slot_field(input logic [31:0] v);
		return v[5:0];
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31])
			return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		return s[31:0];
	endfunction

endpackage

// File: rtl/sqb_front.sv
module sqb_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] width,
	input  logic signed [31:0] height,
	input  logic [31:0]        color,
	input  logic [31:0]        texture_id,
	input  logic               q_full,
	output logic               push,
	output sqb_pkg::job_t      push_job
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_PUSH, ST_SRD, ST_SCMP, ST_FRD, ST_FBIND, ST_FDRAW
	} state_t;

	typedef enum logic [1:0] {
		OP_REJB, OP_VERT, OP_NEW
	} op_t;

	state_t                     state_q;
	op_t                        op_q;
	logic signed [31:0]         x_q, y_q, z_q, w_q, h_q;
	logic [31:0]                color_q, tid_q;
	logic [5:0]                 slot_q;
	logic [sqb_pkg::CNT_W-1:0]  in_use_q;
	logic [sqb_pkg::CNT_W-1:0]  idx_q;
	logic [sqb_pkg::QUAD_W-1:0] quads_q;
	logic [31:0]                rd_data_s1;
	logic [31:0]                tex_mem [sqb_pkg::TEXTURE_SLOTS];
	logic                       table_full;
	logic                       batch_full;
	logic                       idx_at_end;
	logic                       tex_we;
	logic [31:0]                quads32;
	logic [31:0]                count32;

	assign busy       = (state_q != ST_IDLE);
	assign table_full = (32'(in_use_q) >= sqb_pkg::TEXTURE_SLOTS);
	assign batch_full = (32'(quads_q) >= sqb_pkg::MAX_QUADS);
	assign idx_at_end = ((idx_q + sqb_pkg::CNT_W'(1)) == in_use_q);
	assign quads32    = 32'(quads_q);
	assign count32    = (quads32 << 2) + (quads32 << 1);

	always_comb begin
		push_job         = '0;
		push_job.kind    = sqb_pkg::KIND_VERTEX;
		push_job.x       = x_q;
		push_job.y       = y_q;
		push_job.z       = z_q;
		push_job.w       = w_q;
		push_job.h       = h_q;
		push_job.color   = color_q;
		push             = 1'b0;
		unique case (state_q)
			ST_PUSH: begin
				push = !q_full;
				if (op_q == OP_REJB) begin
					push_job.kind = sqb_pkg::KIND_REJ_BATCH;
				end else if (op_q == OP_NEW && table_full) begin
					push_job.kind = sqb_pkg::KIND_REJ_TABLE;
				end else begin
					push_job.slot = (op_q == OP_NEW) ? sqb_pkg::slot_field(32'(in_use_q))
						: slot_q;
				end
			end
			ST_FBIND: begin
				push             = !q_full;
				push_job.kind    = sqb_pkg::KIND_BIND;
				push_job.slot    = sqb_pkg::slot_field(32'(idx_q));
				push_job.texture = rd_data_s1;
			end
			ST_FDRAW: begin
				push           = !q_full;
				push_job.kind  = sqb_pkg::KIND_DRAW;
				push_job.slot  = sqb_pkg::slot_field(32'(in_use_q));
				push_job.count = count32[15:0];
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	assign tex_we = push && (state_q == ST_PUSH) && (op_q == OP_NEW) && !table_full;

	always_ff @(posedge clk) begin
		if (tex_we)
			tex_mem[in_use_q[sqb_pkg::SLOT_AW-1:0]] <= tid_q;
		rd_data_s1 <= tex_mem[idx_q[sqb_pkg::SLOT_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			x_q     <= pos_x;
			y_q     <= pos_y;
			z_q     <= pos_z;
			w_q     <= width;
			h_q     <= height;
			color_q <= color;
			tid_q   <= texture_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= OP_VERT;
			slot_q   <= '0;
			idx_q    <= '0;
			in_use_q <= '0;
			quads_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						idx_q  <= '0;
						slot_q <= '0;
						if (mode) begin
							state_q <= (in_use_q == '0) ? ST_FDRAW : ST_FRD;
						end else if (batch_full) begin
							op_q    <= OP_REJB;
							state_q <= ST_PUSH;
						end else if (texture_id == '0) begin
							op_q    <= OP_VERT;
							state_q <= ST_PUSH;
						end else if (in_use_q == '0) begin
							op_q    <= OP_NEW;
							state_q <= ST_PUSH;
						end else begin
							state_q <= ST_SRD;
						end
					end
				end
				ST_SRD: begin
					state_q <= ST_SCMP;
				end
				ST_SCMP: begin
					if (rd_data_s1 == tid_q) begin
						slot_q  <= sqb_pkg::slot_field(32'(idx_q));
						op_q    <= OP_VERT;
						state_q <= ST_PUSH;
					end else if (idx_at_end) begin
						op_q    <= OP_NEW;
						state_q <= ST_PUSH;
					end else begin
						idx_q   <= idx_q + sqb_pkg::CNT_W'(1);
						state_q <= ST_SRD;
					end
				end
				ST_PUSH: begin
					if (!q_full) begin
						if (op_q != OP_REJB && !(op_q == OP_NEW && table_full))
							quads_q <= quads_q + sqb_pkg::QUAD_W'(1);
						if (tex_we)
							in_use_q <= in_use_q + sqb_pkg::CNT_W'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_FRD: begin
					state_q <= ST_FBIND;
				end
				ST_FBIND: begin
					if (!q_full) begin
						if (idx_at_end) begin
							state_q <= ST_FDRAW;
						end else begin
							idx_q   <= idx_q + sqb_pkg::CNT_W'(1);
							state_q <= ST_FRD;
						end
					end
				end
				ST_FDRAW: begin
					if (!q_full) begin
						quads_q  <= '0;
						in_use_q <= '0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_slots_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(in_use_q) <= sqb_pkg::TEXTURE_SLOTS)
		else $error("slot count beyond table size");
	a_quads_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(quads_q) <= sqb_pkg::MAX_QUADS)
		else $error("quad count beyond batch size");
`endif

endmodule

// File: rtl/sqb_queue.sv
module sqb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sqb_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output sqb_pkg::job_t head
);

	sqb_pkg::job_t              store_q [sqb_pkg::QDEPTH];
	logic [sqb_pkg::QPTR_W-1:0] wptr_q, rptr_q;
	logic [sqb_pkg::QCNT_W-1:0] cnt_q;
	logic                       do_push, do_pop;

	assign full    = (32'(cnt_q) == sqb_pkg::QDEPTH);
	assign valid   = (cnt_q != '0);
	assign head    = store_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push)
			store_q[wptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push)
				wptr_q <= wptr_q + sqb_pkg::QPTR_W'(1);
			if (do_pop)
				rptr_q <= rptr_q + sqb_pkg::QPTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + sqb_pkg::QCNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - sqb_pkg::QCNT_W'(1);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into full queue");
`endif

endmodule

// File: rtl/sqb_back.sv
module sqb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  sqb_pkg::job_t      q_head,
	output logic               pop,
	output logic               strobe,
	output logic [2:0]         kind,
	output logic signed [31:0] vert_x,
	output logic signed [31:0] vert_y,
	output logic signed [31:0] vert_z,
	output logic [31:0]        vert_color,
	output logic               tex_u,
	output logic               tex_v,
	output logic [5:0]         slot,
	output logic [31:0]        bound_texture,
	output logic [15:0]        index_count,
	output logic               last
);

	sqb_pkg::job_t      cur_q;
	logic signed [31:0] xw_q, yh_q;
	logic               active_q;
	logic [1:0]         corner_q;
	logic               last_beat;
	logic               u_c, v_c;

	logic               r_last;
	logic signed [31:0] r_x, r_y, r_z;
	logic [31:0]        r_color, r_tex;
	logic [5:0]         r_slot;
	logic [15:0]        r_count;

	assign last_beat = active_q && (cur_q.kind != sqb_pkg::KIND_VERTEX || corner_q == 2'd3);
	assign pop       = q_valid && (!active_q || last_beat);

	// corners (0,0) (0,1) (1,1) (1,0): u picks x+w, v picks y+h
	assign u_c = corner_q[1];
	assign v_c = corner_q[1] ^ corner_q[0];

	always_comb begin
		r_x     = '0;
		r_y     = '0;
		r_z     = '0;
		r_color = '0;
		r_tex   = '0;
		r_slot  = '0;
		r_count = '0;
		r_last  = 1'b1;
		unique case (cur_q.kind)
			sqb_pkg::KIND_VERTEX: begin
				r_x     = u_c ? xw_q : cur_q.x;
				r_y     = v_c ? yh_q : cur_q.y;
				r_z     = cur_q.z;
				r_color = cur_q.color;
				r_slot  = cur_q.slot;
				r_last  = (corner_q == 2'd3);
			end
			sqb_pkg::KIND_BIND: begin
				r_slot = cur_q.slot;
				r_tex  = cur_q.texture;
				r_last = 1'b0;
			end
			sqb_pkg::KIND_DRAW: begin
				r_slot  = cur_q.slot;
				r_count = cur_q.count;
			end
			default: begin
				r_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_head;
			xw_q  <= sqb_pkg::sat_add(q_head.x, q_head.w);
			yh_q  <= sqb_pkg::sat_add(q_head.y, q_head.h);
		end
		kind          <= cur_q.kind;
		vert_x        <= r_x;
		vert_y        <= r_y;
		vert_z        <= r_z;
		vert_color    <= r_color;
		tex_u         <= (cur_q.kind == sqb_pkg::KIND_VERTEX) && u_c;
		tex_v         <= (cur_q.kind == sqb_pkg::KIND_VERTEX) && v_c;
		slot          <= r_slot;
		bound_texture <= r_tex;
		index_count   <= r_count;
		last          <= r_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			corner_q <= '0;
			strobe   <= 1'b0;
		end else begin
			strobe <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				corner_q <= '0;
			end else if (last_beat) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				corner_q <= corner_q + 2'd1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_quad_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == sqb_pkg::KIND_VERTEX && !last
		|=> strobe && kind == sqb_pkg::KIND_VERTEX)
		else $error("quad vertices not on consecutive beats");
	a_quad_ends_corner: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == sqb_pkg::KIND_VERTEX && last |-> tex_u && !tex_v)
		else $error("quad closed on wrong corner");
	a_record_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (kind == sqb_pkg::KIND_DRAW || kind == sqb_pkg::KIND_REJ_BATCH
		|| kind == sqb_pkg::KIND_REJ_TABLE) |-> last)
		else $error("terminal record without last");
`endif

endmodule

// File: rtl/sprite_quad_batcher_core.sv
// Sprite batcher: turns sprites into quad vertices and batches them for a draw.
// Input: a command beat is taken at a clock edge with start high and busy low.
//   mode 0 submits a sprite, mode 1 flushes the batch.
// Output: each result is shown for one cycle with strobe high; the receiver
//   takes every beat and cannot stall the block. last marks the final beat of
//   a command.
// A sprite gives four vertex beats, or one reject beat. A flush gives one
// binding beat per texture slot in use, then a draw beat.
// A sprite goes from ST_PUSH into the job queue, then into the back's job
//   register, then the output registers; a textured sprite first searches
//   the table entry by entry. Throughput: the result side issues one beat per
//   cycle while jobs wait in the queue; the front searches the texture table
//   through one memory read port, in ST_SRD and ST_SCMP per entry, and a flush
//   reads it in ST_FRD and ST_FBIND per binding. A 4-deep job queue lets the
//   front take the next command while vertices are still going out.
// Reset: clears the batch and slot counts and empties the queue; the texture
//   table needs no clearing since only slots in use are read.
module sprite_quad_batcher_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] width,
	input  logic signed [31:0] height,
	input  logic [31:0]        color,
	input  logic [31:0]        texture_id,
	output logic               strobe,
	output logic [2:0]         kind,
	output logic signed [31:0] vert_x,
	output logic signed [31:0] vert_y,
	output logic signed [31:0] vert_z,
	output logic [31:0]        vert_color,
	output logic               tex_u,
	output logic               tex_v,
	output logic [5:0]         slot,
	output logic [31:0]        bound_texture,
	output logic [15:0]        index_count,
	output logic               last
);

	logic          q_full, q_push, q_pop, q_valid;
	sqb_pkg::job_t push_job, head_job;

	sqb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.width      (width),
		.height     (height),
		.color      (color),
		.texture_id (texture_id),
		.q_full     (q_full),
		.push       (q_push),
		.push_job   (push_job)
	);

	sqb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (head_job)
	);

	sqb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_head        (head_job),
		.pop           (q_pop),
		.strobe        (strobe),
		.kind          (kind),
		.vert_x        (vert_x),
		.vert_y        (vert_y),
		.vert_z        (vert_z),
		.vert_color    (vert_color),
		.tex_u         (tex_u),
		.tex_v         (tex_v),
		.slot          (slot),
		.bound_texture (bound_texture),
		.index_count   (index_count),
		.last          (last)
	);

endmodule
